// ===== design/dbd_pkg.sv =====
// Shared types, constants and the month table for the day-difference core.
`default_nettype none

package dbd_pkg;

  // Field widths
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DoyW   = 9;   // day of year, up to 366
  localparam int unsigned DnumW  = 21;  // absolute day number, below 2^21
  localparam int unsigned DiffW  = 22;  // signed difference

  // Largest year; larger years saturate to it
  localparam logic [YearW-1:0] MaxYear = 12'd4095;

  // floor(x / 100) = (x * Recip100) >> Recip100Shift for x below 4096
  localparam logic [12:0] Recip100      = 13'd5243;
  localparam int unsigned Recip100Shift = 19;
  localparam int unsigned ProdW         = 25;
  localparam int unsigned Q100W         = 6;

  localparam logic [MonthW-1:0] MonJan = 4'd1;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;
  localparam logic [MonthW-1:0] MonDec = 4'd12;

  // One calendar date
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  // Days in a common year before the first of the given month (1..12)
  function automatic logic [DoyW-1:0] month_start(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/dbd_daynum.sv =====
// Three-stage pipeline mapping one date to its absolute day number.
`default_nettype none

module dbd_daynum
  import dbd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire date_t            date_i,
  output logic [DnumW-1:0]      day_num_o
);

  // Stage 1: clamp year and month, look up month start, divide year-1 by 100
  logic [YearW-1:0]  yr;
  logic [MonthW-1:0] mon;
  logic [YearW-1:0]  xm1;
  logic [ProdW-1:0]  prod;

  always_comb begin
    yr   = (date_i.year > MaxYear) ? MaxYear : date_i.year;
    if (date_i.month < MonJan) begin
      mon = MonJan;
    end else if (date_i.month > MonDec) begin
      mon = MonDec;
    end else begin
      mon = date_i.month;
    end
    xm1  = yr - 12'd1;
    prod = ProdW'(xm1) * ProdW'(Recip100);
  end

  logic [YearW-1:0] yr_q;
  logic             zero_q;
  logic [YearW-1:0] xm1_q;
  logic [Q100W-1:0] q100_q;
  logic [DoyW-1:0]  doy0_q;
  logic             late_q;

  always_ff @(posedge clk_i) begin
    yr_q   <= yr;
    zero_q <= (yr == '0);
    xm1_q  <= xm1;
    q100_q <= prod[Recip100Shift +: Q100W];
    doy0_q <= month_start(mon) + DoyW'(date_i.day);
    late_q <= (mon > MonFeb);
  end

  // Stage 2: leap flag, leap years before this year, 365 * year
  logic [YearW-1:0] rem100;
  logic             leap;
  logic [10:0]      leaps;

  always_comb begin
    rem100 = xm1_q - (YearW'(q100_q) * 12'd100);
    // year % 4 == 0 and (year % 100 != 0 or year % 400 == 0); year zero is leap
    leap = zero_q ||
           ((xm1_q[1:0] == 2'b11) && ((rem100 != 12'd99) || (q100_q[1:0] == 2'b11)));
    if (zero_q) begin
      leaps = '0;
    end else begin
      leaps = {1'b0, xm1_q[YearW-1:2]} - 11'(q100_q) + 11'(q100_q[Q100W-1:2]) + 11'd1;
    end
  end

  logic [DnumW-1:0] y365_q;
  logic [10:0]      leaps_q;
  logic [DoyW-1:0]  doy_q;

  always_ff @(posedge clk_i) begin
    y365_q  <= DnumW'(yr_q) * 21'd365;
    leaps_q <= leaps;
    doy_q   <= doy0_q + DoyW'(leap && late_q);
  end

  // Stage 3: sum the parts
  logic [DnumW-1:0] day_num_q;

  always_ff @(posedge clk_i) begin
    day_num_q <= y365_q + DnumW'(leaps_q) + DnumW'(doy_q);
  end

  assign day_num_o = day_num_q;

endmodule

`default_nettype wire

// ===== design/days_between_dates_core.sv =====
// Top level: signed day difference between two Gregorian dates.
//
//   channel  | signals                                         | handshake
//   ---------+-------------------------------------------------+-------------------
//   command  | first_year/month/day_i, second_year/month/day_i | start high, busy low
//   result   | day_difference_o                                | valid_o strobe
//
// Each transaction passes from start to the valid_o strobe through three
// stages per date (clamp and divide by 100, leap count and 365 * year, sum)
// plus one subtract stage. A new transaction is taken every cycle; busy
// stays low. Reset clears only the valid pipeline. The receiver cannot
// stall, so every result is shown for exactly one cycle.
`default_nettype none

module days_between_dates_core
  import dbd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [YearW-1:0]        first_year_i,
  input  wire logic [MonthW-1:0]       first_month_i,
  input  wire logic [DayW-1:0]         first_day_i,
  input  wire logic [YearW-1:0]        second_year_i,
  input  wire logic [MonthW-1:0]       second_month_i,
  input  wire logic [DayW-1:0]         second_day_i,
  output logic                         valid_o,
  output logic signed [DiffW-1:0]      day_difference_o
);

  localparam int unsigned Stages = 4;

  date_t           date_a;
  date_t           date_b;
  logic [DnumW-1:0] num_a;
  logic [DnumW-1:0] num_b;

  assign busy   = 1'b0;
  assign date_a = '{year: first_year_i, month: first_month_i, day: first_day_i};
  assign date_b = '{year: second_year_i, month: second_month_i, day: second_day_i};

  // Map both dates to day numbers in parallel
  dbd_daynum u_num_a (
    .clk_i     (clk_i),
    .date_i    (date_a),
    .day_num_o (num_a)
  );

  dbd_daynum u_num_b (
    .clk_i     (clk_i),
    .date_i    (date_b),
    .day_num_o (num_b)
  );

  // Advance valid bits alongside the data
  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] valid_d;

  assign valid_d = {valid_q[Stages-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Subtract; both day numbers are below 2^21 so the difference fits
  logic signed [DiffW-1:0] diff_q;
  logic signed [DiffW-1:0] diff_d;

  assign diff_d = $signed({1'b0, num_a} - {1'b0, num_b});

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
  end

  assign valid_o          = valid_q[Stages-1];
  assign day_difference_o = diff_q;

endmodule

`default_nettype wire
